[sv/dkps_pkg.sv]
// Shared types and constants for the delayed kicker pulse scheduler.
// No dependencies; imported by every module of the block.
package dkps_pkg;

   localparam int NUM_KICKERS      = 2;
   localparam int SLOTS_PER_KICKER = 2;
   localparam int COUNT_BITS       = 16;
   localparam int FIELD_BITS       = 16;
   localparam int CSR_INDEX_BITS   = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_FIRST  = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_SECOND = CSR_INDEX_BITS'(1);

   localparam logic [FIELD_BITS-1:0] HOLD_RESET = FIELD_BITS'(10);

   typedef logic [COUNT_BITS-1:0] count_type;

   typedef struct packed {
      logic                  is_arm;
      logic                  kicker;
      logic                  slot;
      logic [FIELD_BITS-1:0] delay;
   } dkps_req_type;

   typedef struct packed {
      logic first_on;
      logic second_on;
      logic first_started;
      logic second_started;
      logic first_stopped;
      logic second_stopped;
   } dkps_rsp_type;

endpackage

[sv/dkps_csr.sv]
// Hold-time configuration registers of the kicker scheduler.
// Depends on dkps_pkg.
module dkps_csr
   import dkps_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]             csr_index,
   input  logic [FIELD_BITS-1:0]                 csr_data,
   output logic [NUM_KICKERS-1:0][COUNT_BITS-1:0] hold_cfg
);

   logic [FIELD_BITS-1:0] hold_first_ff, hold_first_in;
   logic [FIELD_BITS-1:0] hold_second_ff, hold_second_in;

   assign csr_ready = 1'b1;

   always_comb begin
      hold_first_in  = hold_first_ff;
      hold_second_in = hold_second_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HOLD_FIRST:  hold_first_in  = csr_data;
            CSR_HOLD_SECOND: hold_second_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_first_ff  <= HOLD_RESET;
         hold_second_ff <= HOLD_RESET;
      end else begin
         hold_first_ff  <= hold_first_in;
         hold_second_ff <= hold_second_in;
      end
   end

   assign hold_cfg[0] = COUNT_BITS'(hold_first_ff);
   assign hold_cfg[1] = COUNT_BITS'(hold_second_ff);

endmodule

[sv/dkps_core.sv]
// Delay slots, hold counters and drive levels; one transaction per fire.
// Depends on dkps_pkg.
module dkps_core
   import dkps_pkg::*;
(
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  fire,
   input  dkps_req_type                          req,
   input  logic [NUM_KICKERS-1:0][COUNT_BITS-1:0] hold_cfg,
   output dkps_rsp_type                          rsp
);

   count_type slot_ff [NUM_KICKERS][SLOTS_PER_KICKER];
   count_type slot_in [NUM_KICKERS][SLOTS_PER_KICKER];
   count_type hold_ff [NUM_KICKERS];
   count_type hold_in [NUM_KICKERS];
   logic [NUM_KICKERS-1:0] lvl_ff, lvl_in;
   logic [NUM_KICKERS-1:0] started, stopped;
   count_type hold_mid [NUM_KICKERS];
   logic [NUM_KICKERS-1:0] lvl_mid;

   always_comb begin
      for (int k = 0; k < NUM_KICKERS; k++) begin
         started[k]  = 1'b0;
         stopped[k]  = 1'b0;
         hold_in[k]  = hold_ff[k];
         hold_mid[k] = hold_ff[k];
         lvl_mid[k]  = lvl_ff[k];
         lvl_in[k]   = lvl_ff[k];
         for (int s = 0; s < SLOTS_PER_KICKER; s++) begin
            slot_in[k][s] = slot_ff[k][s];
         end
         if (req.is_arm) begin
            for (int s = 0; s < SLOTS_PER_KICKER; s++) begin
               if ((32'(req.kicker) == k) && (32'(req.slot) == s)) begin
                  slot_in[k][s] = COUNT_BITS'(req.delay);
               end
            end
         end else begin
            for (int s = 0; s < SLOTS_PER_KICKER; s++) begin
               if (slot_ff[k][s] != '0) begin
                  slot_in[k][s] = slot_ff[k][s] - 1'b1;
                  if (slot_ff[k][s] == COUNT_BITS'(1)) begin
                     started[k] = 1'b1;
                  end
               end
            end
            if (started[k]) begin
               hold_mid[k] = hold_cfg[k];
               lvl_mid[k]  = 1'b1;
            end
            hold_in[k] = hold_mid[k];
            lvl_in[k]  = lvl_mid[k];
            if (hold_mid[k] != '0) begin
               hold_in[k] = hold_mid[k] - 1'b1;
               if (hold_mid[k] == COUNT_BITS'(1)) begin
                  lvl_in[k]  = 1'b0;
                  stopped[k] = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_KICKERS; k++) begin
            hold_ff[k] <= '0;
            for (int s = 0; s < SLOTS_PER_KICKER; s++) begin
               slot_ff[k][s] <= '0;
            end
         end
         lvl_ff <= '0;
      end else if (fire) begin
         hold_ff <= hold_in;
         slot_ff <= slot_in;
         lvl_ff  <= lvl_in;
      end
   end

   assign rsp.first_on       = lvl_in[0];
   assign rsp.second_on      = lvl_in[1];
   assign rsp.first_started  = started[0];
   assign rsp.second_started = started[1];
   assign rsp.first_stopped  = stopped[0];
   assign rsp.second_stopped = stopped[1];

   // a stop always leaves the kicker off
   a_stop_off: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.first_stopped |=> !lvl_ff[0])
      else $error("first kicker on after stop");

   // an expiry with a hold time above one leaves the kicker on
   a_start_on: assert property (@(posedge clock) disable iff (reset)
      fire && rsp.second_started && (hold_cfg[1] > COUNT_BITS'(1)) |=> lvl_ff[1])
      else $error("second kicker off after start");

   // arm transactions never produce events
   a_arm_quiet: assert property (@(posedge clock) disable iff (reset)
      fire && req.is_arm |-> (started == '0) && (stopped == '0))
      else $error("event on arm transaction");

   // idle hold counter and no expiry: level holds
   a_lvl_hold: assert property (@(posedge clock) disable iff (reset)
      fire && !req.is_arm && (hold_ff[0] == '0) && !started[0]
      |=> lvl_ff[0] == $past(lvl_ff[0]))
      else $error("first kicker level changed without cause");

endmodule

[sv/delayed_kicker_pulse_scheduler_top.sv]
// Top level of the delayed kicker pulse scheduler.
// Depends on dkps_pkg, dkps_csr and dkps_core.
//
// Usage:
//   req_* channel: one transaction is a timer tick (req_type = 0) or an arm
//   (req_type = 1) that loads req_delay_ticks into slot req_slot of kicker
//   req_kicker; a delay of 0 cancels that slot.
//   rsp_* channel: one result per request with both drive levels and the
//   start/stop events of that tick (events are 0 for an arm).
//   csr_* port: index 0 and 1 set the hold time of the first and second
//   kicker; other indexes are ignored. csr_ready is always high.
// Pipeline: an accepted request is held in the input register, then its
//   result in the result register, and rsp_valid rises when that is loaded.
//   Throughput: one transaction per cycle while rsp_stall is low; state
//   update happens in the single pass between the two registers.
// Reset: synchronous; clears all slots, hold counters and levels, both
//   hold times return to 10, and both channels empty.
// Stall: while rsp_stall holds a waiting result, the input register keeps
//   one more transaction and req_stall rises only when both are full.
module delayed_kicker_pulse_scheduler_top
   import dkps_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_type,
   input  logic                      req_kicker,
   input  logic                      req_slot,
   input  logic [FIELD_BITS-1:0]     req_delay_ticks,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_first_on,
   output logic                      rsp_second_on,
   output logic                      rsp_first_started,
   output logic                      rsp_second_started,
   output logic                      rsp_first_stopped,
   output logic                      rsp_second_stopped,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]     csr_data
);

   logic [NUM_KICKERS-1:0][COUNT_BITS-1:0] hold_cfg;
   logic         in_valid_ff, in_valid_in;
   dkps_req_type in_req_ff;
   logic         out_valid_ff, out_valid_in;
   dkps_rsp_type out_rsp_ff;
   dkps_rsp_type core_rsp;
   logic         out_free, advance, req_fire;

   dkps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .hold_cfg  (hold_cfg)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   dkps_core u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .req      (in_req_ff),
      .hold_cfg (hold_cfg),
      .rsp      (core_rsp)
   );

   assign in_valid_in  = req_fire || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff.is_arm <= req_type;
         in_req_ff.kicker <= req_kicker;
         in_req_ff.slot   <= req_slot;
         in_req_ff.delay  <= req_delay_ticks;
      end
      if (advance) begin
         out_rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_first_on       = out_rsp_ff.first_on;
   assign rsp_second_on      = out_rsp_ff.second_on;
   assign rsp_first_started  = out_rsp_ff.first_started;
   assign rsp_second_started = out_rsp_ff.second_started;
   assign rsp_first_stopped  = out_rsp_ff.first_stopped;
   assign rsp_second_stopped = out_rsp_ff.second_stopped;

   // input register never overwritten while its transaction waits
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_fire)
      else $error("input transaction overwritten");

   // a stalled result stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   // input side is stalled only when both registers are full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff)
      else $error("stall without full pipeline");

endmodule
